@@ rtl/time_window_classifier_unit_defines.svh @@
// Assertion macros for the time window classifier.
`ifndef TIME_WINDOW_CLASSIFIER_UNIT_DEFINES_SVH
`define TIME_WINDOW_CLASSIFIER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define TWC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define TWC_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define TWC_ASSERT(label, clk, rst_n, prop)
`define TWC_ASSERT_NR(label, clk, prop)
`endif
`endif

@@ rtl/twc_pkg.sv @@
// Shared types and constants for the time window classifier.
`default_nettype none
package twc_pkg;
  localparam int unsigned MaxWindows = 16;
  localparam int unsigned IdxW = $clog2(MaxWindows);
  localparam int unsigned CntW = $clog2(MaxWindows + 1);
  localparam logic [31:0] WinReset = 32'd86400;
  localparam logic [63:0] UsPerSec = 64'd1000000;
  // 1e6 = 2^6 * 15625: shift first, then multiply by ceil(2^72 / 15625),
  // exact for every shifted magnitude below 2^58
  localparam int unsigned SecShift = 6;
  localparam logic [63:0] SecMagic = 64'(((128'd1 << 72) / 128'd15625) + 128'd1);

  typedef enum logic [1:0] {
    KindHit = 2'd0,
    KindNew = 2'd1,
    KindNear = 2'd2
  } kind_e;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

@@ rtl/twc_div.sv @@
// Iterative signed 64-bit remainder unit, one bit per cycle, remainder takes the dividend sign.
`default_nettype none
module twc_div import twc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire div_req_t    req_i,
  output logic             done_o,
  output logic [63:0]      rem_o
);
  logic [63:0] q_q, q_d, r_q, r_d, d_q, d_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, nr_q, nr_d, done_q, done_d;
  logic [64:0] trial;

  assign trial = {r_q, q_q[63]} - {1'b0, d_q};

  always_comb begin
    q_d = q_q; r_d = r_q; d_d = d_q; cnt_d = cnt_q;
    busy_d = busy_q; nr_d = nr_q; done_d = 1'b0;
    if (req_i.start) begin
      q_d = req_i.dividend[63] ? -req_i.dividend : req_i.dividend;
      d_d = req_i.divisor;
      r_d = '0;
      cnt_d = 7'd0;
      busy_d = 1'b1;
      nr_d = req_i.dividend[63];
    end else if (busy_q) begin
      if (!trial[64]) begin
        r_d = trial[63:0];
        q_d = {q_q[62:0], 1'b1};
      end else begin
        r_d = {r_q[62:0], q_q[63]};
        q_d = {q_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; d_q <= d_d; nr_q <= nr_d;
  end

  assign done_o = done_q;
  assign rem_o  = nr_q ? -r_q : r_q;
endmodule
`default_nettype wire

@@ rtl/twc_table.sv @@
// Known-window table: one synchronous memory with a registered read port.
`default_nettype none
module twc_table import twc_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire logic [63:0]     wdata_i,
  input  wire logic [IdxW-1:0] raddr_i,
  output logic [63:0]          rdata_o
);
  logic [63:0] mem [MaxWindows];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ rtl/time_window_classifier_unit.sv @@
// Top level of the time window classifier.
// Each item runs a reciprocal seconds multiply, a serial remainder and a scaling multiply, then
// scans the table; a nearest pick then walks the table one entry at a time, with a read followed
// by a compare for each entry. Only one item is in flight: the next transfer is taken the cycle
// after the result loads, and output stalls hold the result until it is taken.
// Reset clears the count and control; table holds garbage until written; window 86400 s.
`default_nettype none
`include "time_window_classifier_unit_defines.svh"
module time_window_classifier_unit import twc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        start_new_i,
  input  wire logic [63:0] timestamp_us_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      window_us_o,
  output logic [1:0]       match_kind_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);
  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StRecip = 9'b000000010,
    StDivW  = 9'b000000100,
    StMul   = 9'b000001000,
    StScan  = 9'b000010000,
    StSwap  = 9'b000100000,
    StNear  = 9'b001000000,
    StNRd   = 9'b010000000,
    StOut   = 9'b100000000
  } st_e;

  st_e st_q, st_d;
  logic [31:0] win_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;   // next entry to read
  logic [IdxW-1:0] hit_q, hit_d;
  logic [63:0] bestdiff_q, bestdiff_d;
  logic [63:0] sec_q, sec_d, win_val_q, win_val_d, res_q, res_d;
  logic [1:0]  kind_q, kind_d;
  logic        rd_pend_q, rd_pend_d;   // rdata valid for entry idx_q-1
  logic        out_v_q, out_v_d;
  // shared 32x32 multiplier, one partial product per cycle
  logic [63:0]  mag_q, mag_d;
  logic         neg_q, neg_d;
  logic [127:0] acc_q, acc_d;
  logic [2:0]   step_q, step_d;
  logic [31:0]  mul_a, mul_b;
  logic [1:0]   mul_sh;
  logic [63:0]  prod;
  logic [127:0] pp;
  logic [55:0]  secmag;
  logic [63:0]  sec_calc;

  div_req_t    dreq;
  logic        ddone;
  logic [63:0] drem;
  logic        we;
  logic [IdxW-1:0] waddr, raddr;
  logic [63:0] wdata, rdata, diff, e0_q, e0_d;
  logic [63:0] ua, ub;

  twc_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .rem_o(drem));
  twc_table u_tab (.clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
                   .raddr_i(raddr), .rdata_o(rdata));

  assign ua = rdata ^ 64'h8000_0000_0000_0000;
  assign ub = win_val_q ^ 64'h8000_0000_0000_0000;
  assign diff = (ua >= ub) ? ua - ub : ub - ua;

  assign prod = 64'(mul_a) * 64'(mul_b);
  assign pp = {64'd0, prod} << {mul_sh, 5'd0};
  // seconds magnitude = (|ts| >> 6) * SecMagic >> 72, sign restored for C truncation
  assign secmag = acc_q[127:72];
  assign sec_calc = neg_q ? -{8'd0, secmag} : {8'd0, secmag};

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; idx_d = idx_q; hit_d = hit_q;
    bestdiff_d = bestdiff_q; sec_d = sec_q; win_val_d = win_val_q; res_d = res_q;
    kind_d = kind_q; rd_pend_d = 1'b0; out_v_d = out_v_q; e0_d = e0_q;
    mag_d = mag_q; neg_d = neg_q; acc_d = acc_q; step_d = step_q;
    mul_a = '0; mul_b = '0; mul_sh = '0;
    dreq = '0; we = 1'b0; waddr = '0; wdata = win_val_q; raddr = idx_q[IdxW-1:0];
    if (out_v_q && out_ready_i) out_v_d = 1'b0;
    case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          if (start_new_i) cnt_d = '0;
          neg_d = timestamp_us_i[63];
          mag_d = (timestamp_us_i[63] ? -timestamp_us_i : timestamp_us_i) >> SecShift;
          acc_d = '0;
          step_d = '0;
          st_d = StRecip;
        end
      end
      StRecip: begin
        if (step_q == 3'd4) begin
          sec_d = sec_calc;
          dreq.start = 1'b1;
          dreq.dividend = sec_calc;
          dreq.divisor = {32'd0, (win_q == 32'd0) ? 32'd1 : win_q};
          st_d = StDivW;
        end else begin
          mul_a = step_q[1] ? mag_q[63:32] : mag_q[31:0];
          mul_b = step_q[0] ? SecMagic[63:32] : SecMagic[31:0];
          mul_sh = {1'b0, step_q[1]} + {1'b0, step_q[0]};
          acc_d = acc_q + pp;
          step_d = step_q + 3'd1;
        end
      end
      StDivW: begin
        if (ddone) begin
          sec_d = sec_q - drem;
          acc_d = '0;
          step_d = '0;
          st_d = StMul;
        end
      end
      StMul: begin
        // low 64 bits of seconds * 1e6, two partial products
        if (step_q == 3'd2) begin
          win_val_d = acc_q[63:0];
          idx_d = '0;
          raddr = '0;
          st_d = StScan;
          if (cnt_q != '0) begin
            rd_pend_d = 1'b1;
            idx_d = CntW'(1);
            raddr = '0;
          end
        end else begin
          mul_a = step_q[0] ? sec_q[63:32] : sec_q[31:0];
          mul_b = UsPerSec[31:0];
          mul_sh = {1'b0, step_q[0]};
          acc_d = acc_q + pp;
          step_d = step_q + 3'd1;
        end
      end
      StScan: begin
        // rdata holds entry idx_q-1 when rd_pend_q
        if (rd_pend_q) begin
          if (idx_q == CntW'(1)) e0_d = rdata;
          if (rdata == win_val_q) begin
            hit_d = IdxW'(idx_q - CntW'(1));
            st_d = StSwap;
          end else if (idx_q < cnt_q) begin
            raddr = idx_q[IdxW-1:0];
            idx_d = idx_q + CntW'(1);
            rd_pend_d = 1'b1;
          end else begin
            rd_pend_d = 1'b0;
          end
        end
        if (st_d == StScan && !rd_pend_d) begin
          if (cnt_q < CntW'(MaxWindows)) begin
            we = 1'b1;
            waddr = cnt_q[IdxW-1:0];
            cnt_d = cnt_q + CntW'(1);
            res_d = win_val_q; kind_d = KindNew; st_d = StOut;
          end else begin
            raddr = '0;
            idx_d = CntW'(1);
            bestdiff_d = '1;
            st_d = StNRd;
          end
        end
      end
      StSwap: begin
        // entry 0 gets the hit value, entry hit gets old entry 0
        we = 1'b1;
        waddr = hit_q;
        wdata = e0_q;
        res_d = win_val_q; kind_d = KindHit; st_d = StNear;
      end
      StNear: begin
        if (kind_q == KindHit) begin
          we = 1'b1; waddr = '0; wdata = win_val_q; st_d = StOut;
        end else begin
          // nearest walk: rdata holds entry idx_q-1, strict compare keeps lowest index
          if (idx_q == CntW'(1) || diff < bestdiff_q) begin
            bestdiff_d = diff;
            res_d = rdata;
          end
          if (idx_q == CntW'(MaxWindows)) begin
            kind_d = KindNear; st_d = StOut;
          end else begin
            raddr = idx_q[IdxW-1:0];
            idx_d = idx_q + CntW'(1);
            st_d = StNRd;
          end
        end
      end
      StNRd: begin
        kind_d = KindNear; st_d = StNear;
        raddr = IdxW'(idx_q - CntW'(1));
      end
      StOut: begin
        if (!out_v_q || out_ready_i) begin
          out_v_d = 1'b1; st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; out_v_q <= 1'b0; win_q <= WinReset;
      idx_q <= '0; rd_pend_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; out_v_q <= out_v_d; idx_q <= idx_d;
      rd_pend_q <= rd_pend_d;
      if (cfg_we_i) win_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d; bestdiff_q <= bestdiff_d; sec_q <= sec_d;
    win_val_q <= win_val_d; kind_q <= kind_d; e0_q <= e0_d;
    mag_q <= mag_d; neg_q <= neg_d; acc_q <= acc_d; step_q <= step_d;
    if (st_q == StOut && (!out_v_q || out_ready_i)) begin
      window_us_o <= res_q; match_kind_o <= kind_q;
    end
    res_q <= res_d;
  end

  assign in_ready_o  = (st_q == StIdle);
  assign out_valid_o = out_v_q;

  `TWC_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CntW'(MaxWindows))
  `TWC_ASSERT(a_busy_no_ready, clk_i, rst_ni, (st_q != StIdle) |-> !in_ready_o)
  `TWC_ASSERT(a_accept_clear, clk_i, rst_ni,
    (in_valid_i && in_ready_o && start_new_i) |=> (cnt_q == '0))
  `TWC_ASSERT(a_out_hold, clk_i, rst_ni, (out_v_q && !out_ready_i) |=> out_v_q)
endmodule
`default_nettype wire
